// ===== hw/rtl/codebook_delta_audio_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// Codebook delta audio decoder: assertion macros
// Concurrent check helpers shared by the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef CODEBOOK_DELTA_AUDIO_DECODER_DEFINES_SVH
`define CODEBOOK_DELTA_AUDIO_DECODER_DEFINES_SVH

// same-cycle implication
`define CBDA_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CBDA_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/cbda_pkg.sv =====
// ----------------------------------------------------------------------------
// Codebook delta audio decoder package
// Block geometry, widths and configuration register indexes.
// ----------------------------------------------------------------------------
package cbda_pkg;

	localparam int BODY_UNIT   = 256;
	localparam int TABLE_DEPTH = 16;

	// mode 0: 16 codes, nibbles; mode 1: 4 codes, 2-bit, each applied twice
	localparam int CODES0 = 16;
	localparam int CODES1 = 4;
	localparam int BODY0  = 4 * BODY_UNIT;
	localparam int BODY1  = 2 * BODY_UNIT;
	localparam int HDR0   = 2 + 2 * CODES0;
	localparam int HDR1   = 2 + 2 * CODES1;
	localparam int BLK0   = HDR0 + BODY0;
	localparam int BLK1   = HDR1 + BODY1;
	localparam int SPB0   = 2 * BODY0;
	localparam int SPB1   = 8 * BODY1;

	localparam int POS_W   = $clog2(BLK0 + 1);
	localparam int CNT_W   = $clog2(SPB1 + 1);
	localparam int TIDX_W  = $clog2(TABLE_DEPTH);
	localparam int BLKN_W  = 16;
	localparam int FIRST_W = BLKN_W + CNT_W;
	localparam int SUB_W   = 3;

	localparam logic [SUB_W-1:0] SUB_LAST0 = SUB_W'(1);
	localparam logic [SUB_W-1:0] SUB_LAST1 = SUB_W'(7);

	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 2;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_MODE          = cfg_idx_t'(0);
	localparam cfg_idx_t REG_TOTAL_SAMPLES = cfg_idx_t'(1);
	localparam cfg_idx_t REG_BLOCK_COUNT   = cfg_idx_t'(2);

	typedef logic signed [15:0] sample_t;

endpackage

// ===== hw/rtl/cbda_stream_if.sv =====
// ----------------------------------------------------------------------------
// Codebook delta audio decoder stream interfaces
// Valid/ready channels for coded bytes in and decoded samples out.
// ----------------------------------------------------------------------------
interface cbda_byte_if;
	logic                        valid;
	logic                        ready;
	logic [7:0]                  data_byte;
	logic                        block_begin;
	logic [cbda_pkg::BLKN_W-1:0] block_number;

	modport source (output valid, data_byte, block_begin, block_number, input ready);
	modport sink (input valid, data_byte, block_begin, block_number, output ready);
endinterface

interface cbda_sample_if;
	logic              valid;
	logic              ready;
	cbda_pkg::sample_t sample;
	logic              last_of_block;

	modport source (output valid, sample, last_of_block, input ready);
	modport sink (input valid, sample, last_of_block, output ready);
endinterface

// ===== hw/rtl/codebook_delta_audio_decoder.sv =====
// ----------------------------------------------------------------------------
// Codebook delta audio decoder
// Decodes coded audio blocks byte by byte into clamped 16-bit samples.
// ----------------------------------------------------------------------------
// Usage:
//   byte_stream carries the bytes of a block: start sample (LE), delta table
//   (LE 16-bit entries), then body bytes; block_begin marks the first byte
//   and block_number is read with it. sample_stream returns one sample per
//   transfer, last_of_block set on the final wanted sample of a block.
//   Registers (mode, total_samples, block_count) are written through the
//   cfg_* port while the decoder is idle.
// Timing:
//   A byte is registered on transfer and each of its samples in the output
//   register. Header bytes go one per cycle; a body byte gives 2 samples in
//   mode 0, 8 in mode 1, one per cycle unless sample_stream stalls. The single
//   accumulator adder, stepped once per sample, sets that rate. A new byte
//   is taken in the cycle its predecessor issues its last sample.
// Reset:
//   arst_n clears control state and registers; the delta table is not
//   cleared and must be loaded by a block header before use.
// Backpressure:
//   While sample_stream stalls, the pending sample holds and the byte in
//   work pauses; byte_stream ready drops until it can finish.
// ----------------------------------------------------------------------------
`include "codebook_delta_audio_decoder_defines.svh"

module codebook_delta_audio_decoder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write_en,
	input  cbda_pkg::cfg_idx_t          cfg_index,
	input  logic [cbda_pkg::CFG_W-1:0]  cfg_data,
	cbda_byte_if.sink                   byte_stream,
	cbda_sample_if.source               sample_stream
);
	import cbda_pkg::*;

	// configuration
	logic              mode_q;
	logic [31:0]       total_q;
	logic [BLKN_W-1:0] bcount_q;

	// input register
	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              begin_s1;
	logic [BLKN_W-1:0] blk_s1;

	// decoder state
	logic [31:0]      acc_q;
	logic [POS_W-1:0] pos_q;
	logic [7:0]       low_q;
	logic [CNT_W-1:0] emitted_q;
	logic [CNT_W-1:0] wanted_q;
	logic             active_q;
	logic [SUB_W-1:0] sub_q;
	logic [15:0]      table_q [TABLE_DEPTH];

	// output register
	logic    out_valid_q;
	sample_t sample_q;
	logic    last_q;

	logic [POS_W-1:0]   hdr_len, blk_len, pos_inc, k;
	logic               in_range, body_byte, work, fire, finish, can_emit;
	logic               step_last, emit_last, done_after, byte_go;
	logic [CNT_W-1:0]   emitted_inc, spb;
	logic [FIRST_W-1:0] first;
	logic [31:0]        rest, acc_next;
	logic               start_ok;
	logic [CNT_W-1:0]   wanted_new;
	logic [3:0]         code;
	logic signed [15:0] delta_raw, delta;
	logic signed [16:0] d17;
	logic               tbl_we;
	logic [TIDX_W-1:0]  tbl_idx;
	sample_t            clamped;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			total_q  <= '0;
			bcount_q <= '0;
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_MODE:          mode_q   <= cfg_data[0];
				REG_TOTAL_SAMPLES: total_q  <= cfg_data[31:0];
				REG_BLOCK_COUNT:   bcount_q <= cfg_data[BLKN_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------ geometry
	assign hdr_len   = mode_q ? POS_W'(HDR1) : POS_W'(HDR0);
	assign blk_len   = mode_q ? POS_W'(BLK1) : POS_W'(BLK0);
	assign spb       = mode_q ? CNT_W'(SPB1) : CNT_W'(SPB0);
	assign pos_inc   = pos_q + 1'b1;
	assign k         = pos_q - POS_W'(2);
	assign in_range  = pos_q < blk_len;
	assign body_byte = pos_q >= hdr_len;

	// block start: first sample index and how many samples this block owes
	assign first      = FIRST_W'(blk_s1) * FIRST_W'(spb);
	assign start_ok   = (blk_s1 < bcount_q) && (32'(first) < total_q);
	assign rest       = total_q - 32'(first);
	assign wanted_new = (rest < 32'(spb)) ? rest[CNT_W-1:0] : spb;

	// ------------------------------------------------------------ sample step
	always_comb begin
		if (mode_q) begin
			case (sub_q[2:1])
				2'd0:    code = {2'b00, byte_s1[1:0]};
				2'd1:    code = {2'b00, byte_s1[3:2]};
				2'd2:    code = {2'b00, byte_s1[5:4]};
				default: code = {2'b00, byte_s1[7:6]};
			endcase
		end else begin
			code = sub_q[0] ? byte_s1[7:4] : byte_s1[3:0];
		end
	end

	assign delta_raw = (int'(code) < TABLE_DEPTH) ? table_q[code[TIDX_W-1:0]] : '0;
	// halve toward zero: bias negatives by one before the arithmetic shift
	assign d17       = {delta_raw[15], delta_raw} + 17'(delta_raw[15]);
	assign delta     = mode_q ? d17[16:1] : delta_raw;
	assign acc_next  = acc_q + {{16{delta[15]}}, delta};

	always_comb begin
		if ($signed(acc_next) > 32'sd32767)
			clamped = 16'sh7FFF;
		else if ($signed(acc_next) < -32'sd32768)
			clamped = 16'sh8000;
		else
			clamped = acc_next[15:0];
	end

	assign emitted_inc = emitted_q + 1'b1;
	assign emit_last   = emitted_inc == wanted_q;
	assign done_after  = emitted_inc >= wanted_q;
	assign step_last   = (mode_q ? (sub_q == SUB_LAST1) : (sub_q == SUB_LAST0)) || done_after;

	assign work     = valid_s1 && !begin_s1 && active_q && in_range && body_byte
		&& (emitted_q < wanted_q);
	assign can_emit = !out_valid_q || sample_stream.ready;
	assign fire     = work && can_emit;
	assign finish   = work ? (fire && step_last) : valid_s1;
	assign byte_go  = byte_stream.valid && byte_stream.ready;

	assign byte_stream.ready = !valid_s1 || finish;

	// ------------------------------------------------------------ input reg
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (byte_stream.ready)
			valid_s1 <= byte_stream.valid;
	end

	always_ff @(posedge clk) begin
		if (byte_go) begin
			byte_s1  <= byte_stream.data_byte;
			begin_s1 <= byte_stream.block_begin;
			blk_s1   <= byte_stream.block_number;
		end
	end

	// ------------------------------------------------------------ delta table
	assign tbl_idx = k[TIDX_W:1];
	assign tbl_we  = valid_s1 && !begin_s1 && active_q && in_range && !body_byte
		&& (pos_q >= POS_W'(2)) && k[0] && (int'(k >> 1) < TABLE_DEPTH);

	always_ff @(posedge clk) begin
		if (tbl_we)
			table_q[tbl_idx] <= {byte_s1, low_q};
	end

	// ------------------------------------------------------------ block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			pos_q     <= '0;
			low_q     <= '0;
			emitted_q <= '0;
			wanted_q  <= '0;
			active_q  <= 1'b0;
			sub_q     <= '0;
		end else if (valid_s1) begin
			if (begin_s1) begin
				active_q  <= start_ok;
				pos_q     <= start_ok ? POS_W'(1) : '0;
				emitted_q <= '0;
				wanted_q  <= start_ok ? wanted_new : '0;
				sub_q     <= '0;
				if (start_ok)
					low_q <= byte_s1;
			end else if (active_q) begin
				if (!in_range) begin
					active_q <= 1'b0;
				end else if (!body_byte) begin
					if (pos_q == '0)
						low_q <= byte_s1;
					else if (pos_q == POS_W'(1))
						acc_q <= {{16{byte_s1[7]}}, byte_s1, low_q};
					else if (!k[0])
						low_q <= byte_s1;
					pos_q <= pos_inc;
					if (pos_inc >= blk_len)
						active_q <= 1'b0;
				end else if (work) begin
					if (fire) begin
						acc_q     <= acc_next;
						emitted_q <= emitted_inc;
						if (step_last) begin
							sub_q <= '0;
							pos_q <= pos_inc;
							if (pos_inc >= blk_len || done_after)
								active_q <= 1'b0;
						end else begin
							sub_q <= sub_q + 1'b1;
						end
					end
				end else begin
					// body byte with nothing left to give
					pos_q    <= pos_inc;
					active_q <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------ output reg
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (fire)
			out_valid_q <= 1'b1;
		else if (sample_stream.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			sample_q <= clamped;
			last_q   <= emit_last;
		end
	end

	assign sample_stream.valid         = out_valid_q;
	assign sample_stream.sample        = sample_q;
	assign sample_stream.last_of_block = last_q;

	// ------------------------------------------------------------ checks
	`CBDA_ASSERT_NOW(a_no_overwrite, clk, arst_n, out_valid_q && !sample_stream.ready, !fire, "sample overwritten while output stalled")
	`CBDA_ASSERT_NOW(a_count_bound, clk, arst_n, active_q, emitted_q < wanted_q, "active block has no samples left")
	`CBDA_ASSERT_NEXT(a_last_ends_block, clk, arst_n, fire && emit_last, !active_q, "block still active after its last sample")

endmodule

// ===== bench/cbda_decode_check.sv =====
// ----------------------------------------------------------------------------
// Codebook delta audio decoder: decode checker
// Watches the register port and both streams, decodes every accepted byte
// on its own copy of the decoder state and compares each sample transfer,
// field by field, with the oldest sample still owed.
// ----------------------------------------------------------------------------
module cbda_decode_check
	import cbda_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write_en,
	input  cfg_idx_t            cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	cbda_byte_if                coded,
	cbda_sample_if              pcm,
	output int                  errors,
	output int                  outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		sample_t sample;
		logic    last_of_block;
	} pcm_word_t;

	pcm_word_t   pcm_due[$];
	pcm_word_t   oldest;

	logic        mode_r;
	logic [31:0] total_r;
	logic [15:0] count_r;

	logic [31:0] acc;
	logic [15:0] deltas [TABLE_DEPTH];
	int unsigned pos;
	logic [7:0]  low_hold;
	int unsigned emitted;
	int unsigned wanted;
	logic        active;

	function automatic int table_delta(input logic [3:0] idx);
		if (idx >= TABLE_DEPTH)
			return 0;
		return $signed(deltas[idx]);
	endfunction

	function automatic void push_pcm();
		sample_t s;
		if ($signed(acc) > 32767)
			s = 16'sh7fff;
		else if ($signed(acc) < -32768)
			s = 16'sh8000;
		else
			s = sample_t'(acc[15:0]);
		pcm_due.push_back('{sample: s, last_of_block: (emitted + 1 == wanted)});
		emitted++;
	endfunction

	// advance the decoder by one coded byte, queueing the samples it owes
	task automatic decode_byte(input logic [7:0] b, input logic beg, input logic [15:0] blk);
		longint unsigned span;
		longint unsigned first;
		longint unsigned rest;
		int unsigned     hdr;
		int unsigned     blk_bytes;
		int unsigned     cur;
		int              half;
		if (beg) begin
			span = mode_r ? SPB1 : SPB0;
			first = span * blk;
			active = 1'b0;
			pos = 0;
			emitted = 0;
			wanted = 0;
			if (blk >= count_r || first >= total_r)
				return;
			rest = total_r - first;
			wanted = (rest < span) ? int'(rest) : int'(span);
			active = 1'b1;
			low_hold = b;
			pos = 1;
			return;
		end
		if (!active)
			return;
		hdr = mode_r ? HDR1 : HDR0;
		blk_bytes = mode_r ? BLK1 : BLK0;
		cur = pos;
		if (cur >= blk_bytes) begin
			active = 1'b0;
			return;
		end
		if (cur == 0) begin
			low_hold = b;
		end else if (cur == 1) begin
			acc = {{16{b[7]}}, b, low_hold};
		end else if (cur < hdr) begin
			if ((cur - 2) % 2 == 0)
				low_hold = b;
			else if ((cur - 2) / 2 < TABLE_DEPTH)
				deltas[(cur - 2) / 2] = {b, low_hold};
		end else if (!mode_r) begin
			for (int s = 0; s < 8 && emitted < wanted; s += 4) begin
				acc += table_delta(4'(b >> s));
				push_pcm();
			end
		end else begin
			// each 2-bit code: half the delta, applied twice
			for (int s = 0; s < 8 && emitted < wanted; s += 2) begin
				half = table_delta(4'((b >> s) & 8'h3)) / 2;
				acc += half;
				push_pcm();
				if (emitted >= wanted)
					break;
				acc += half;
				push_pcm();
			end
		end
		pos = cur + 1;
		if (pos >= blk_bytes || (cur >= hdr && emitted >= wanted))
			active = 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_r = 1'b0;
			total_r = '0;
			count_r = '0;
			acc = '0;
			foreach (deltas[i])
				deltas[i] = '0;
			pos = 0;
			low_hold = '0;
			emitted = 0;
			wanted = 0;
			active = 1'b0;
			pcm_due.delete();
			errors = 0;
		end else begin
			if (cfg_write_en) begin
				case (cfg_index)
				REG_MODE:          mode_r = cfg_data[0];
				REG_TOTAL_SAMPLES: total_r = cfg_data[31:0];
				REG_BLOCK_COUNT:   count_r = cfg_data[15:0];
				default: ;
				endcase
			end
			// output side first: a byte taken now cannot owe a sample yet
			if (pcm.valid && pcm.ready) begin
				if (pcm_due.size() == 0) begin
					$error("sample %0d transferred with nothing owed", pcm.sample);
					errors++;
				end else begin
					oldest = pcm_due.pop_front();
					if (pcm.sample !== oldest.sample) begin
						$error("sample: expected %0d, got %0d", oldest.sample, pcm.sample);
						errors++;
					end
					if (pcm.last_of_block !== oldest.last_of_block) begin
						$error("last_of_block: expected %0b, got %0b",
							oldest.last_of_block, pcm.last_of_block);
						errors++;
					end
				end
			end
			if (coded.valid && coded.ready)
				decode_byte(coded.data_byte, coded.block_begin, coded.block_number);
		end
		outstanding = pcm_due.size();
	end

endmodule

// ===== bench/tb_codebook_delta_audio_decoder.sv =====
// ----------------------------------------------------------------------------
// Codebook delta audio decoder testbench
// Feeds short directed blocks, then randomized phases of well-formed, cut and
// out-of-range blocks under several register settings, then one long block
// at the widest settings. Both streams idle at random; the checker beside
// the decoder predicts and compares every sample.
// ----------------------------------------------------------------------------
module tb_codebook_delta_audio_decoder;
	import cbda_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 380;
	localparam int DRAIN_TAIL   = 20;
	localparam int WHOLE        = 1 << 30;
	localparam int LONG_BODY    = 24;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_write_en;
	cfg_idx_t         cfg_index;
	logic [CFG_W-1:0] cfg_data;

	int   errors;
	int   outstanding;
	int   items_sent;
	logic cur_mode;
	bit   byte_burst;
	bit   sink_burst;

	cbda_byte_if   coded_bytes ();
	cbda_sample_if pcm_out ();

	codebook_delta_audio_decoder uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.byte_stream   (coded_bytes),
		.sample_stream (pcm_out)
	);

	cbda_decode_check decode_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.coded        (coded_bytes),
		.pcm          (pcm_out),
		.errors       (errors),
		.outstanding  (outstanding)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#10_000_000;
		$display("Mismatches found");
		$finish;
	end

	// sample sink: random stall before every transfer, with stall-free stretches
	initial begin
		int stall;
		int served;
		pcm_out.ready <= 1'b0;
		served = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (served % 40 == 0)
				sink_burst = ($urandom_range(0, 3) == 0);
			stall = sink_burst ? 0 : $urandom_range(0, 19);
			if (stall != 0) begin
				pcm_out.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pcm_out.ready <= 1'b1;
			do @(posedge clk); while (!pcm_out.valid);
			served++;
		end
	end

	function automatic logic [15:0] pick_word();
		case ($urandom_range(0, 7))
		0: return 16'h7fff;
		1: return 16'h8000;
		2: return 16'h0000;
		3: return 16'hffff;
		4: return 16'h0001;
		5: return 16'($urandom_range(0, 255) - 128);
		default: return 16'($urandom);
		endcase
	endfunction

	task automatic program_decoder(input logic m, input logic [31:0] total,
		input logic [15:0] count);
		cfg_write_en <= 1'b1;
		cfg_index <= REG_MODE;
		cfg_data <= {31'($urandom), m};
		@(posedge clk);
		cfg_index <= REG_TOTAL_SAMPLES;
		cfg_data <= total;
		@(posedge clk);
		cfg_index <= REG_BLOCK_COUNT;
		cfg_data <= {16'($urandom), count};
		@(posedge clk);
		cfg_write_en <= 1'b0;
		cur_mode = m;
	endtask

	task automatic send_byte(input logic [7:0] b, input logic beg, input logic [15:0] blk);
		int gap;
		gap = byte_burst ? 0 : $urandom_range(0, 19);
		if (gap != 0) begin
			coded_bytes.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		coded_bytes.valid <= 1'b1;
		coded_bytes.data_byte <= b;
		coded_bytes.block_begin <= beg;
		coded_bytes.block_number <= blk;
		do @(posedge clk); while (!coded_bytes.ready);
	endtask

	// sends at most cut bytes; the first carries block_begin
	task automatic send_list(input logic [15:0] blk, input logic [7:0] octets[$],
		input int cut);
		for (int i = 0; i < octets.size() && i < cut; i++) begin
			send_byte(octets[i], i == 0, (i == 0) ? blk : 16'($urandom));
			items_sent++;
		end
	endtask

	task automatic send_block(input logic [15:0] blk, input int n_body, input int cut);
		logic [7:0]  octets[$];
		logic [15:0] w;
		int          codes;
		codes = cur_mode ? CODES1 : CODES0;
		for (int i = 0; i <= codes; i++) begin
			w = pick_word();
			octets.push_back(w[7:0]);
			octets.push_back(w[15:8]);
		end
		for (int i = 0; i < n_body; i++)
			octets.push_back(8'($urandom));
		send_list(blk, octets, cut);
	endtask

	// block the decoder will ignore, plus trailing bytes it also ignores
	task automatic send_stray(input logic [15:0] blk);
		send_byte(8'($urandom), 1'b1, blk);
		repeat ($urandom_range(0, 3))
			send_byte(8'($urandom), 1'b0, 16'($urandom));
	endtask

	task automatic drain();
		coded_bytes.valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	task automatic run_phase();
		logic        m;
		int          kind;
		int          span;
		int          per;
		int          hdr;
		int          rem;
		int          need;
		int          pick;
		logic [15:0] target;
		logic [15:0] count;
		logic [31:0] total;
		m = 1'($urandom_range(0, 1));
		span = m ? SPB1 : SPB0;
		per = m ? 8 : 2;
		hdr = m ? HDR1 : HDR0;
		kind = $urandom_range(0, 7);
		target = 16'($urandom_range(0, 3));
		rem = m ? $urandom_range(1, 60) : $urandom_range(1, 24);
		if (kind == 0) begin
			count = 16'hffff;
			total = 32'hffff_ffff;
		end else if (kind == 1) begin
			count = 16'h0000;
			total = $urandom;
		end else if (kind == 2) begin
			count = 16'hffff;
			total = 32'h0;
		end else begin
			count = target + 16'($urandom_range(1, 3));
			total = 32'(target) * span + rem;
		end
		need = (rem + per - 1) / per;
		drain();
		program_decoder(m, total, count);
		repeat ($urandom_range(3, 6)) begin
			byte_burst = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 7) == 0)
				drain();
			pick = $urandom_range(0, 9);
			if (kind == 1 || kind == 2) begin
				send_stray(16'($urandom));
			end else if (kind == 0) begin
				// full-size blocks here: abandon them a few body bytes in
				if (pick < 2)
					send_stray(16'hffff);
				else
					send_block((pick < 5) ? 16'hfffe : 16'($urandom_range(0, 16'hfffe)),
						$urandom_range(1, 12), WHOLE);
			end else if (pick == 7) begin
				send_block(target, need, $urandom_range(1, hdr + need - 1));
			end else if (pick == 8) begin
				send_stray(($urandom_range(0, 1) == 0) ? count + 16'($urandom_range(0, 9))
					: target + 16'($urandom_range(1, 3)));
			end else if (pick == 9 && target != 0) begin
				send_block(16'($urandom_range(0, target - 1)), $urandom_range(1, 10), WHOLE);
			end else begin
				// extra bytes past the wanted samples are ignored
				send_block(target, need + $urandom_range(0, 2), WHOLE);
			end
		end
	endtask

	initial begin
		logic [7:0] octets[$];
		arst_n <= 1'b0;
		cfg_write_en <= 1'b0;
		cfg_index <= REG_MODE;
		cfg_data <= '0;
		coded_bytes.valid <= 1'b0;
		coded_bytes.data_byte <= '0;
		coded_bytes.block_begin <= 1'b0;
		coded_bytes.block_number <= '0;
		cur_mode = 1'b0;
		byte_burst = 1'b0;
		items_sent = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// start at max, deltas at the extremes: clamps high, block cut mid byte
		program_decoder(1'b1, 32'd6, 16'd1);
		octets = {8'hff, 8'h7f, 8'hff, 8'h7f, 8'h00, 8'h80, 8'hff, 8'hff,
			8'h01, 8'h00, 8'h00};
		send_list(16'd0, octets, WHOLE);
		// out-of-range block and a stray byte while idle
		send_byte(8'h5a, 1'b1, 16'd1);
		send_byte(8'ha5, 1'b0, 16'd0);
		drain();
		// second block of the sound; -1 and 1 halve to zero, clamps low
		program_decoder(1'b1, SPB1 + 9, 16'd2);
		octets = {8'h00, 8'h80, 8'hff, 8'hff, 8'h01, 8'h00, 8'h00, 8'h80,
			8'hff, 8'h7f, 8'h1b, 8'he4};
		send_list(16'd1, octets, WHOLE);

		items_sent = 0;
		while (items_sent < RANDOM_ITEMS)
			run_phase();

		// a long block at the widest settings
		drain();
		byte_burst = 1'b0;
		program_decoder(1'b1, 32'hffff_ffff, 16'hffff);
		send_block(16'hfffe, LONG_BODY, WHOLE);
		drain();

		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
